[sv/gesd_pkg.sv]
// Shared types and constants for the gamepad event state decoder.
// No dependencies; every other file of the block imports this package.
package gesd_pkg;

	localparam int VAL_W  = 17;
	localparam int DZ_W   = 15;
	localparam int OFF_W  = 18;
	localparam int SPAN_W = 17;
	localparam int MAG_W  = 10;
	localparam int AXIS_W = 11;
	localparam int NUM_W  = 34;
	localparam int REM_W  = 27;
	localparam int DSH_W  = SPAN_W + MAG_W - 1;
	localparam int CNT_W  = 4;

	localparam logic [15:0] AXIS_CENTRE = 16'd32768;
	localparam logic [15:0] FULL_SCALE  = 16'd1023;
	localparam logic [15:0] RAW_MAX     = 16'd65535;
	localparam int unsigned AXIS_LIMIT_I = 1023;
	localparam int unsigned LIM_I =
		(int'(FULL_SCALE) > AXIS_LIMIT_I) ? AXIS_LIMIT_I : int'(FULL_SCALE);
	localparam logic [MAG_W-1:0] AXIS_LIM = MAG_W'(LIM_I);

	localparam logic [DZ_W-1:0] DEADBAND_RST = 15'd3500;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_FAIL,
		CMD_BUTTON,
		CMD_TRIG,
		CMD_DPAD_V,
		CMD_DPAD_H,
		CMD_AXIS
	} cmd_kind_t;

	// One classified event as it travels from the front to the back.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [3:0]         idx;
		logic               pressed;
		logic [MAG_W-1:0]   level;
		logic [1:0]         dpad;
		logic               axis_low;
		logic [OFF_W-1:0]   off;
	} cmd_t;

endpackage

[sv/gesd_front.sv]
// Front end: accepts input events and classifies them into commands.
// Depends on gesd_pkg for the command type and axis constants.
module gesd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 event_valid,
	output logic                 event_ready,
	input  logic [15:0]          event_type,
	input  logic [15:0]          event_code,
	input  logic signed [16:0]   event_value,
	input  logic                 read_failed,
	output logic                 cmd_valid,
	output gesd_pkg::cmd_t       cmd_data,
	input  logic                 cmd_ready
);
	import gesd_pkg::*;

	localparam logic [15:0] CODE_KEY_A      = 16'd304;
	localparam logic [15:0] CODE_KEY_B      = 16'd305;
	localparam logic [15:0] CODE_KEY_X      = 16'd306;
	localparam logic [15:0] CODE_KEY_Y      = 16'd307;
	localparam logic [15:0] CODE_KEY_LB     = 16'd308;
	localparam logic [15:0] CODE_KEY_RB     = 16'd309;
	localparam logic [15:0] CODE_KEY_SELECT = 16'd310;
	localparam logic [15:0] CODE_KEY_START  = 16'd311;
	localparam logic [15:0] CODE_KEY_LPRESS = 16'd312;
	localparam logic [15:0] CODE_KEY_RPRESS = 16'd313;
	localparam logic [15:0] CODE_KEY_HOME   = 16'd172;
	localparam logic [15:0] CODE_TRIG_L     = 16'd10;
	localparam logic [15:0] CODE_TRIG_R     = 16'd9;
	localparam logic [15:0] CODE_DPAD_V     = 16'd17;
	localparam logic [15:0] CODE_DPAD_H     = 16'd16;
	localparam logic [15:0] CODE_LSTICK_V   = 16'd1;
	localparam logic [15:0] CODE_LSTICK_H   = 16'd0;
	localparam logic [15:0] CODE_RSTICK_V   = 16'd5;
	localparam logic [15:0] CODE_RSTICK_H   = 16'd2;

	logic        valid_s1;
	cmd_t        cmd_s1;
	cmd_t        cmd_c;
	logic signed [OFF_W:0] val_x;
	logic signed [OFF_W:0] ctr_x;
	logic signed [OFF_W:0] diff_x;
	logic        low_c;

	assign val_x  = (OFF_W+1)'(event_value);
	assign ctr_x  = $signed({3'b000, AXIS_CENTRE});
	assign low_c  = val_x < ctr_x;
	assign diff_x = low_c ? (ctr_x - val_x) : (val_x - ctr_x);

	always_comb begin
		cmd_c          = '0;
		cmd_c.kind     = CMD_NONE;
		cmd_c.pressed  = event_value != '0;
		if (event_value < 0) begin
			cmd_c.level = '0;
		end else if (event_value > 17'sd1023) begin
			cmd_c.level = AXIS_LIM | MAG_W'(1023);
		end else begin
			cmd_c.level = event_value[MAG_W-1:0];
		end
		// Positive one selects the down or right flag, minus one up or left.
		if (event_value == 17'sd1) begin
			cmd_c.dpad = 2'b10;
		end else if (event_value == -17'sd1) begin
			cmd_c.dpad = 2'b01;
		end else begin
			cmd_c.dpad = 2'b00;
		end
		cmd_c.axis_low = low_c;
		cmd_c.off      = diff_x[OFF_W-1:0];
		if (read_failed) begin
			cmd_c.kind = CMD_FAIL;
		end else if (event_type != '0) begin
			unique case (event_code)
				CODE_KEY_B:      begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd0;  end
				CODE_KEY_Y:      begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd1;  end
				CODE_KEY_X:      begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd2;  end
				CODE_KEY_A:      begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd3;  end
				CODE_KEY_LB:     begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd4;  end
				CODE_KEY_RB:     begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd5;  end
				CODE_KEY_START:  begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd6;  end
				CODE_KEY_SELECT: begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd7;  end
				CODE_KEY_HOME:   begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd8;  end
				CODE_KEY_LPRESS: begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd9;  end
				CODE_KEY_RPRESS: begin cmd_c.kind = CMD_BUTTON; cmd_c.idx = 4'd10; end
				CODE_TRIG_L:     begin cmd_c.kind = CMD_TRIG;   cmd_c.idx = 4'd0;  end
				CODE_TRIG_R:     begin cmd_c.kind = CMD_TRIG;   cmd_c.idx = 4'd1;  end
				CODE_DPAD_V:     begin cmd_c.kind = CMD_DPAD_V; end
				CODE_DPAD_H:     begin cmd_c.kind = CMD_DPAD_H; end
				CODE_LSTICK_V:   begin cmd_c.kind = CMD_AXIS;   cmd_c.idx = 4'd0;  end
				CODE_LSTICK_H:   begin cmd_c.kind = CMD_AXIS;   cmd_c.idx = 4'd1;  end
				CODE_RSTICK_V:   begin cmd_c.kind = CMD_AXIS;   cmd_c.idx = 4'd2;  end
				CODE_RSTICK_H:   begin cmd_c.kind = CMD_AXIS;   cmd_c.idx = 4'd3;  end
				default:         begin cmd_c.kind = CMD_NONE; end
			endcase
		end
	end

	assign event_ready = !valid_s1 || cmd_ready;
	assign cmd_valid   = valid_s1;
	assign cmd_data    = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (event_ready) begin
			valid_s1 <= event_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (event_ready && event_valid) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

[sv/gesd_queue.sv]
// Short command queue between the front end and the back end.
// Depends on gesd_pkg for the command type and queue depth.
module gesd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  gesd_pkg::cmd_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output gesd_pkg::cmd_t  pop_data
);
	import gesd_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

	cmd_t               mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_QW-1:0]  count_q;
	logic               push;
	logic               pop;

	assign push_ready = count_q != CNT_QW'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_QW'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");

endmodule

[sv/gesd_scale.sv]
// Iterative stick axis scaler: dead zone removal, one multiply, saturation
// check and a one-bit-per-cycle restoring divide. Depends on gesd_pkg.
module gesd_scale (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      axis_low,
	input  logic [gesd_pkg::OFF_W-1:0] off,
	input  logic [gesd_pkg::DZ_W-1:0]  deadband,
	output logic                      done,
	output logic signed [gesd_pkg::AXIS_W-1:0] value
);
	import gesd_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_CHK,
		S_DIV
	} scale_state_t;

	scale_state_t       state_q;
	logic               done_q;
	logic               low_q;
	logic [OFF_W-1:0]   diff_q;
	logic [SPAN_W-1:0]  den_q;
	logic [NUM_W-1:0]   num_q;
	logic [REM_W-1:0]   cap_q;
	logic [REM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [MAG_W-1:0]   mag_q;
	logic [SPAN_W-1:0]  span_c;
	logic               fits_c;

	assign span_c = axis_low ? SPAN_W'(AXIS_CENTRE) : SPAN_W'(RAW_MAX - AXIS_CENTRE);
	assign fits_c = rem_q >= REM_W'(dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (off <= OFF_W'(deadband)) begin
							done_q <= 1'b1;
						end else if (span_c <= SPAN_W'(deadband)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (num_q >= NUM_W'(cap_q)) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					low_q  <= axis_low;
					diff_q <= off - OFF_W'(deadband);
					den_q  <= span_c - SPAN_W'(deadband);
					if (off <= OFF_W'(deadband)) begin
						mag_q <= '0;
					end else begin
						mag_q <= AXIS_LIM;
					end
				end
			end
			S_MUL: begin
				num_q <= NUM_W'(FULL_SCALE) * NUM_W'(diff_q);
				cap_q <= REM_W'(AXIS_LIM) * REM_W'(den_q);
			end
			S_CHK: begin
				// Below the cap the quotient fits in MAG_W bits.
				rem_q <= num_q[REM_W-1:0];
				dsh_q <= {den_q, (MAG_W-1)'(0)};
				cnt_q <= CNT_W'(MAG_W - 1);
				if (num_q < NUM_W'(cap_q)) begin
					mag_q <= '0;
				end
			end
			S_DIV: begin
				if (fits_c) begin
					rem_q <= rem_q - REM_W'(dsh_q);
				end
				mag_q <= {mag_q[MAG_W-2:0], fits_c};
				dsh_q <= dsh_q >> 1;
				cnt_q <= cnt_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done  = done_q;
	assign value = low_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

	a_mag_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (mag_q <= AXIS_LIM))
		else $error("scaled axis magnitude above limit");

endmodule

[sv/gesd_back.sv]
// Back end: holds the gamepad snapshot, executes commands from the queue
// and registers each updated snapshot for output. Depends on gesd_pkg and gesd_scale.
module gesd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [gesd_pkg::DZ_W-1:0]  deadband,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  gesd_pkg::cmd_t             cmd_data,
	output logic                       result_valid,
	input  logic                       result_ready,
	output logic [10:0]                button_bits,
	output logic [9:0]                 left_trigger,
	output logic [9:0]                 right_trigger,
	output logic [3:0]                 dpad_bits,
	output logic signed [10:0]         left_vertical,
	output logic signed [10:0]         left_horizontal,
	output logic signed [10:0]         right_vertical,
	output logic signed [10:0]         right_horizontal,
	output logic                       disconnected
);
	import gesd_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE,
		B_AXIS,
		B_EMIT
	} back_state_t;

	back_state_t             state_q;
	logic [10:0]             buttons_q;
	logic [MAG_W-1:0]        trig_q [2];
	logic [3:0]              dpad_q;
	logic signed [AXIS_W-1:0] axis_q [4];
	logic                    disc_q;
	logic [1:0]              aidx_q;
	logic                    rv_q;
	logic                    emit_c;
	logic                    sc_start;
	logic                    sc_done;
	logic signed [AXIS_W-1:0] sc_value;

	assign cmd_ready = state_q == B_IDLE;
	assign sc_start  = cmd_ready && cmd_valid && !disc_q && cmd_data.kind == CMD_AXIS;
	assign emit_c    = state_q == B_EMIT && (!rv_q || result_ready);

	gesd_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (sc_start),
		.axis_low  (cmd_data.axis_low),
		.off       (cmd_data.off),
		.deadband  (deadband),
		.done      (sc_done),
		.value     (sc_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= B_IDLE;
			buttons_q        <= '0;
			trig_q[0]        <= '0;
			trig_q[1]        <= '0;
			dpad_q           <= '0;
			for (int i = 0; i < 4; i++) begin
				axis_q[i] <= '0;
			end
			disc_q           <= 1'b0;
			aidx_q           <= '0;
			rv_q             <= 1'b0;
			button_bits      <= '0;
			left_trigger     <= '0;
			right_trigger    <= '0;
			dpad_bits        <= '0;
			left_vertical    <= '0;
			left_horizontal  <= '0;
			right_vertical   <= '0;
			right_horizontal <= '0;
			disconnected     <= 1'b0;
		end else begin
			if (emit_c) begin
				rv_q <= 1'b1;
			end else if (result_ready) begin
				rv_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						if (sc_start) begin
							state_q <= B_AXIS;
						end else begin
							state_q <= B_EMIT;
						end
						if (!disc_q) begin
							unique case (cmd_data.kind)
								CMD_FAIL:   disc_q <= 1'b1;
								CMD_BUTTON: buttons_q[cmd_data.idx] <= cmd_data.pressed;
								CMD_TRIG:   trig_q[cmd_data.idx[0]] <= cmd_data.level;
								CMD_DPAD_V: dpad_q[1:0] <= cmd_data.dpad;
								CMD_DPAD_H: dpad_q[3:2] <= cmd_data.dpad;
								CMD_AXIS:   aidx_q <= cmd_data.idx[1:0];
								default: begin
								end
							endcase
						end
					end
				end
				B_AXIS: begin
					if (sc_done) begin
						axis_q[aidx_q] <= sc_value;
						state_q        <= B_EMIT;
					end
				end
				B_EMIT: begin
					// The output copy lets the next command run while this result waits.
					if (emit_c) begin
						state_q          <= B_IDLE;
						button_bits      <= buttons_q;
						left_trigger     <= trig_q[0];
						right_trigger    <= trig_q[1];
						dpad_bits        <= dpad_q;
						left_vertical    <= axis_q[0];
						left_horizontal  <= axis_q[1];
						right_vertical   <= axis_q[2];
						right_horizontal <= axis_q[3];
						disconnected     <= disc_q;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign result_valid = rv_q;

	a_disc_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(disc_q) |-> disc_q)
		else $error("disconnect flag cleared without reset");

	a_no_scale_when_disc: assert property (@(posedge clk) disable iff (!arst_n)
		disc_q |-> !sc_start)
		else $error("axis scaling started while disconnected");

endmodule

[sv/gamepad_event_state_decoder_core.sv]
// Top level of the gamepad event state decoder.
// Depends on gesd_pkg, gesd_front, gesd_queue and gesd_back.
//
// Usage:
// Events enter on the event channel (event_valid/event_ready) with their
// type, code, value and read_failed flag. Every accepted event produces
// exactly one transfer on the result channel (result_valid/result_ready)
// carrying the full controller snapshot after that event is applied.
// The dead zone register is written through cfg_valid/cfg_ready/cfg_data;
// cfg_ready is always high and writes are meant for idle periods only.
// Buttons, triggers, d-pad and ignored events pass through the front end
// register, the queue and the back end's emit state. Connected stick events
// also run the scaler: an offset inside the dead zone ends in its idle state,
// a saturating value after the multiply and the saturation check, and
// any other after the multiply, the check and the restoring divide. The
// front end and queue take new events while the back end is still busy.
// The front end register and a two-entry queue keep accepting events
// while the receiver stalls; once they fill, event_ready drops.
// Reset clears the snapshot and disconnect flag and sets the dead zone
// to 3500.
module gamepad_event_state_decoder_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                event_valid,
	output logic                event_ready,
	input  logic [15:0]         event_type,
	input  logic [15:0]         event_code,
	input  logic signed [16:0]  event_value,
	input  logic                read_failed,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [14:0]         cfg_data,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [10:0]         button_bits,
	output logic [9:0]          left_trigger,
	output logic [9:0]          right_trigger,
	output logic [3:0]          dpad_bits,
	output logic signed [10:0]  left_vertical,
	output logic signed [10:0]  left_horizontal,
	output logic signed [10:0]  right_vertical,
	output logic signed [10:0]  right_horizontal,
	output logic                disconnected
);
	import gesd_pkg::*;

	logic [DZ_W-1:0] deadband_q;
	logic            f_valid;
	logic            f_ready;
	cmd_t            f_data;
	logic            q_valid;
	logic            q_ready;
	cmd_t            q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RST;
		end else if (cfg_valid && cfg_ready) begin
			deadband_q <= cfg_data;
		end
	end

	gesd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_type  (event_type),
		.event_code  (event_code),
		.event_value (event_value),
		.read_failed (read_failed),
		.cmd_valid   (f_valid),
		.cmd_data    (f_data),
		.cmd_ready   (f_ready)
	);

	gesd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	gesd_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.deadband         (deadband_q),
		.cmd_valid        (q_valid),
		.cmd_ready        (q_ready),
		.cmd_data         (q_data),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.button_bits      (button_bits),
		.left_trigger     (left_trigger),
		.right_trigger    (right_trigger),
		.dpad_bits        (dpad_bits),
		.left_vertical    (left_vertical),
		.left_horizontal  (left_horizontal),
		.right_vertical   (right_vertical),
		.right_horizontal (right_horizontal),
		.disconnected     (disconnected)
	);

endmodule

[dv/tb_gamepad_event_state_decoder_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for gamepad_event_state_decoder_core.
// Depends on gesd_pkg and the core; a scoreboard class predicts every snapshot.
module tb_gamepad_event_state_decoder_core;
	import gesd_pkg::*;

	localparam logic [15:0] TYPE_SYNC       = 16'd0;
	localparam logic [15:0] TYPE_KEY        = 16'd1;
	localparam logic [15:0] TYPE_ABS        = 16'd3;
	localparam logic [15:0] CODE_BTN_A      = 16'd304;
	localparam logic [15:0] CODE_BTN_B      = 16'd305;
	localparam logic [15:0] CODE_BTN_X      = 16'd306;
	localparam logic [15:0] CODE_BTN_Y      = 16'd307;
	localparam logic [15:0] CODE_BTN_LB     = 16'd308;
	localparam logic [15:0] CODE_BTN_RB     = 16'd309;
	localparam logic [15:0] CODE_BTN_SELECT = 16'd310;
	localparam logic [15:0] CODE_BTN_START  = 16'd311;
	localparam logic [15:0] CODE_BTN_HOME   = 16'd172;
	localparam logic [15:0] CODE_BTN_LPRESS = 16'd312;
	localparam logic [15:0] CODE_BTN_RPRESS = 16'd313;
	localparam logic [15:0] CODE_TRIG_LEFT  = 16'd10;
	localparam logic [15:0] CODE_TRIG_RIGHT = 16'd9;
	localparam logic [15:0] CODE_DPAD_V     = 16'd17;
	localparam logic [15:0] CODE_DPAD_H     = 16'd16;
	localparam logic [15:0] CODE_AXIS_LV    = 16'd1;
	localparam logic [15:0] CODE_AXIS_LH    = 16'd0;
	localparam logic [15:0] CODE_AXIS_RV    = 16'd5;
	localparam logic [15:0] CODE_AXIS_RH    = 16'd2;
	localparam logic [15:0] CODE_UNKNOWN    = 16'd999;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int TAIL_CYCLES    = 20;
	localparam int HOLD_CYCLES    = 400;

	typedef struct packed {
		logic [10:0]        buttons;
		logic [9:0]         ltrig;
		logic [9:0]         rtrig;
		logic [3:0]         dpad;
		logic signed [10:0] lv;
		logic signed [10:0] lh;
		logic signed [10:0] rv;
		logic signed [10:0] rh;
		logic               disc;
	} snapshot_t;

	function automatic logic [15:0] button_code(int slot);
		case (slot)
			0: return CODE_BTN_B;
			1: return CODE_BTN_Y;
			2: return CODE_BTN_X;
			3: return CODE_BTN_A;
			4: return CODE_BTN_LB;
			5: return CODE_BTN_RB;
			6: return CODE_BTN_START;
			7: return CODE_BTN_SELECT;
			8: return CODE_BTN_HOME;
			9: return CODE_BTN_LPRESS;
			default: return CODE_BTN_RPRESS;
		endcase
	endfunction

	function automatic logic [15:0] axis_code(int slot);
		case (slot)
			0: return CODE_AXIS_LV;
			1: return CODE_AXIS_LH;
			2: return CODE_AXIS_RV;
			default: return CODE_AXIS_RH;
		endcase
	endfunction

	class gamepad_snapshot_board;
		snapshot_t          expected_q[$];
		logic [10:0]        buttons;
		logic [9:0]         trig_lvl[2];
		logic [3:0]         dpad;
		logic signed [10:0] axis_val[4];
		logic               disc_flag;
		logic [14:0]        deadband;
		int                 errors;

		function new();
			buttons = '0;
			trig_lvl[0] = '0;
			trig_lvl[1] = '0;
			dpad = '0;
			for (int i = 0; i < 4; i++)
				axis_val[i] = '0;
			disc_flag = 1'b0;
			deadband = DEADBAND_RST;
			errors = 0;
		endfunction

		function void set_deadband(logic [14:0] dz);
			deadband = dz;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function int button_slot(logic [15:0] code);
			for (int k = 0; k < 11; k++)
				if (button_code(k) == code)
					return k;
			return -1;
		endfunction

		function int axis_slot(logic [15:0] code);
			for (int k = 0; k < 4; k++)
				if (axis_code(k) == code)
					return k;
			return -1;
		endfunction

		// Dead zone removal and linear scaling of the remaining offset.
		function logic signed [10:0] scale_axis(logic signed [16:0] value);
			longint v;
			longint centre;
			longint dz;
			longint off;
			longint span;
			longint mag;
			longint lim;
			bit     below;
			v = value;
			centre = AXIS_CENTRE;
			dz = deadband;
			lim = LIM_I;
			below = (v < centre);
			off = below ? centre - v : v - centre;
			span = below ? centre : longint'(RAW_MAX) - centre;
			if (off <= dz)
				mag = 0;
			else if (span <= dz)
				mag = lim;
			else begin
				mag = (longint'(FULL_SCALE) * (off - dz)) / (span - dz);
				if (mag > lim)
					mag = lim;
			end
			return below ? 11'(-mag) : 11'(mag);
		endfunction

		function void note_event(logic [15:0] ev_type, logic [15:0] code,
				logic signed [16:0] value, logic fail);
			int        slot;
			snapshot_t snap;
			if (!disc_flag) begin
				if (fail)
					disc_flag = 1'b1;
				else if (ev_type != TYPE_SYNC) begin
					slot = button_slot(code);
					if (slot >= 0)
						buttons[slot] = (value != 0);
					else if (code == CODE_TRIG_LEFT || code == CODE_TRIG_RIGHT) begin
						slot = (code == CODE_TRIG_LEFT) ? 0 : 1;
						if (value < 0)
							trig_lvl[slot] = '0;
						else if (value > 1023)
							trig_lvl[slot] = 10'd1023;
						else
							trig_lvl[slot] = value[9:0];
					end else if (code == CODE_DPAD_V) begin
						dpad[1:0] = (value == 1) ? 2'b10 : ((value == -1) ? 2'b01 : 2'b00);
					end else if (code == CODE_DPAD_H) begin
						dpad[3:2] = (value == 1) ? 2'b10 : ((value == -1) ? 2'b01 : 2'b00);
					end else begin
						slot = axis_slot(code);
						if (slot >= 0)
							axis_val[slot] = scale_axis(value);
					end
				end
			end
			snap.buttons = buttons;
			snap.ltrig = trig_lvl[0];
			snap.rtrig = trig_lvl[1];
			snap.dpad = dpad;
			snap.lv = axis_val[0];
			snap.lh = axis_val[1];
			snap.rv = axis_val[2];
			snap.rh = axis_val[3];
			snap.disc = disc_flag;
			expected_q.push_back(snap);
		endfunction

		function void compare_field(string name, int expv, int gotv);
			if (expv != gotv) begin
				errors++;
				$display("[%0t] %s mismatch: expected %0d, actual %0d",
					$time, name, expv, gotv);
			end
		endfunction

		function void check_result(snapshot_t got);
			snapshot_t want;
			if (expected_q.size() == 0) begin
				errors++;
				$display("[%0t] result transfer with no event pending", $time);
				return;
			end
			want = expected_q.pop_front();
			compare_field("button_bits", want.buttons, got.buttons);
			compare_field("left_trigger", want.ltrig, got.ltrig);
			compare_field("right_trigger", want.rtrig, got.rtrig);
			compare_field("dpad_bits", want.dpad, got.dpad);
			compare_field("left_vertical", $signed(want.lv), $signed(got.lv));
			compare_field("left_horizontal", $signed(want.lh), $signed(got.lh));
			compare_field("right_vertical", $signed(want.rv), $signed(got.rv));
			compare_field("right_horizontal", $signed(want.rh), $signed(got.rh));
			compare_field("disconnected", want.disc, got.disc);
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               event_valid = 1'b0;
	logic               event_ready;
	logic [15:0]        event_type = '0;
	logic [15:0]        event_code = '0;
	logic signed [16:0] event_value = '0;
	logic               read_failed = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [14:0]        cfg_data = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [10:0]        button_bits;
	logic [9:0]         left_trigger;
	logic [9:0]         right_trigger;
	logic [3:0]         dpad_bits;
	logic signed [10:0] left_vertical;
	logic signed [10:0] left_horizontal;
	logic signed [10:0] right_vertical;
	logic signed [10:0] right_horizontal;
	logic               disconnected;

	gamepad_snapshot_board board = new();
	int send_idle_pct = 0;
	int rcv_idle_pct = 0;
	int results_seen = 0;
	int hold_left = 0;

	gamepad_event_state_decoder_core DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.event_valid      (event_valid),
		.event_ready      (event_ready),
		.event_type       (event_type),
		.event_code       (event_code),
		.event_value      (event_value),
		.read_failed      (read_failed),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.result_valid     (result_valid),
		.result_ready     (result_ready),
		.button_bits      (button_bits),
		.left_trigger     (left_trigger),
		.right_trigger    (right_trigger),
		.dpad_bits        (dpad_bits),
		.left_vertical    (left_vertical),
		.left_horizontal  (left_horizontal),
		.right_vertical   (right_vertical),
		.right_horizontal (right_horizontal),
		.disconnected     (disconnected)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Result side: checks every transfer and applies random or long stalls.
	always @(posedge clk) begin : result_monitor
		snapshot_t got;
		if (arst_n) begin
			if (result_valid && result_ready) begin
				got.buttons = button_bits;
				got.ltrig = left_trigger;
				got.rtrig = right_trigger;
				got.dpad = dpad_bits;
				got.lv = left_vertical;
				got.lh = left_horizontal;
				got.rv = right_vertical;
				got.rh = right_horizontal;
				got.disc = disconnected;
				board.check_result(got);
				results_seen++;
				// Long stalls let the input side fill up and back off.
				if (results_seen == 120 || results_seen == 550)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else
				result_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((event_valid && event_ready) || (result_valid && result_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	// Leaves valid high after the transfer so back-to-back events need no gap.
	task automatic send_event(input logic [15:0] ev_type, input logic [15:0] code,
			input logic signed [16:0] value, input logic fail);
		while ($urandom_range(99) < send_idle_pct) begin
			event_valid <= 1'b0;
			@(posedge clk);
		end
		event_valid <= 1'b1;
		event_type <= ev_type;
		event_code <= code;
		event_value <= value;
		read_failed <= fail;
		do @(posedge clk); while (!event_ready);
		board.note_event(ev_type, code, value, fail);
	endtask

	task automatic write_deadband(input logic [14:0] dz);
		event_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= dz;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.set_deadband(dz);
	endtask

	function automatic int full_value();
		return $urandom_range(65536) - 1;
	endfunction

	task automatic random_event(input bit allow_fail);
		int          pick;
		int          v;
		int          centre;
		int          dz;
		logic [15:0] ev_type;
		logic [15:0] code;
		logic        fail;
		pick = $urandom_range(99);
		fail = allow_fail ? 1'($urandom_range(1)) : 1'b0;
		ev_type = TYPE_ABS;
		centre = AXIS_CENTRE;
		dz = board.deadband;
		if (pick < 15) begin
			// Noise: any type and code, values from -1 to 65535, sync events included.
			ev_type = 16'($urandom);
			code = 16'($urandom);
			v = full_value();
		end else if (pick < 40) begin
			ev_type = TYPE_KEY;
			code = button_code($urandom_range(10));
			case ($urandom_range(9))
				0, 1, 2, 3: v = 1;
				4, 5, 6: v = 0;
				default: v = full_value();
			endcase
		end else if (pick < 55) begin
			code = $urandom_range(1) ? CODE_TRIG_LEFT : CODE_TRIG_RIGHT;
			v = ($urandom_range(9) < 8) ? $urandom_range(1023) : full_value();
		end else if (pick < 70) begin
			code = $urandom_range(1) ? CODE_DPAD_V : CODE_DPAD_H;
			v = ($urandom_range(3) < 3) ? $urandom_range(2) - 1 : full_value();
		end else if (pick < 95) begin
			code = axis_code($urandom_range(3));
			case ($urandom_range(9))
				0, 1, 2, 3, 4: v = $urandom_range(65535);
				5, 6: v = $urandom_range(1) ? centre + dz + $urandom_range(6) - 3
					: centre - dz - $urandom_range(6) + 3;
				7: begin
					case ($urandom_range(3))
						0: v = 0;
						1: v = 65535;
						2: v = -1;
						default: v = centre;
					endcase
				end
				default: v = centre + $urandom_range(2 * dz + 2) - dz - 1;
			endcase
			if (v < -1)
				v = -1;
			if (v > 65535)
				v = 65535;
		end else begin
			code = 16'($urandom_range(400));
			v = full_value();
		end
		send_event(ev_type, code, 17'(v), fail);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 12;
		rcv_idle_pct <= 75;

		// Directed part, with the reset dead zone of 3500.
		send_event(TYPE_SYNC, CODE_BTN_B, 17'sd1, 1'b0);
		send_event(TYPE_KEY, CODE_BTN_B, 17'sd1, 1'b0);
		send_event(TYPE_KEY, CODE_BTN_Y, -17'sd1, 1'b0);
		send_event(TYPE_KEY, CODE_BTN_HOME, 17'sd65535, 1'b0);
		send_event(TYPE_KEY, CODE_BTN_B, 17'sd0, 1'b0);
		send_event(16'hFFFF, CODE_BTN_RPRESS, 17'sd2, 1'b0);
		send_event(TYPE_ABS, CODE_TRIG_LEFT, 17'sd2000, 1'b0);
		send_event(TYPE_ABS, CODE_TRIG_RIGHT, -17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_TRIG_RIGHT, 17'sd1023, 1'b0);
		send_event(TYPE_ABS, CODE_TRIG_LEFT, 17'sd1024, 1'b0);
		send_event(TYPE_ABS, CODE_DPAD_V, 17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_DPAD_V, -17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_DPAD_H, 17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_DPAD_H, -17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_DPAD_H, 17'sd5, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_LV, 17'sd0, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_LH, 17'sd65535, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_RV, 17'sd32768, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_RH, -17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_LV, 17'(32768 + 3500), 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_LV, 17'(32768 + 3501), 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_LH, 17'(32768 - 3501), 1'b0);
		send_event(TYPE_ABS, CODE_UNKNOWN, 17'sd1, 1'b0);

		write_deadband(15'd0);
		repeat (100) random_event(1'b0);
		write_deadband(15'd32000);
		repeat (100) random_event(1'b0);

		send_idle_pct = 75;
		rcv_idle_pct <= 12;
		write_deadband(15'($urandom_range(32000)));
		repeat (100) random_event(1'b0);
		write_deadband(DEADBAND_RST);
		repeat (100) random_event(1'b0);

		send_idle_pct = 0;
		rcv_idle_pct <= 0;
		write_deadband(15'($urandom_range(32000)));
		repeat (100) random_event(1'b0);
		write_deadband(15'd1);
		repeat (100) random_event(1'b0);

		// The disconnect flag is sticky and only reset clears it, so the
		// read failure comes last; everything after it must leave the
		// snapshot frozen.
		send_event(TYPE_KEY, CODE_BTN_A, 17'sd1, 1'b1);
		send_event(TYPE_KEY, CODE_BTN_RB, 17'sd1, 1'b0);
		send_event(TYPE_ABS, CODE_AXIS_RV, 17'sd0, 1'b0);
		repeat (40) random_event(1'b1);

		event_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[gamepad_event_state_decoder_core.f]
sv/gesd_pkg.sv
sv/gesd_front.sv
sv/gesd_queue.sv
sv/gesd_scale.sv
sv/gesd_back.sv
sv/gamepad_event_state_decoder_core.sv
dv/tb_gamepad_event_state_decoder_core.sv
